FILE: hw/rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared widths, status codes and the cumulative month table for the
// day count fraction core.
// ----------------------------------------------------------------------------
package dcf_pkg;

   localparam int FRAC_BITS_DEF = 32;

   localparam int MODE_W   = 3;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 47;

   // day number of the largest year handled, with margin
   localparam int DN_W     = 23;
   // magnitude of a numerator and size of a denominator
   localparam int MAG_W    = 32;
   localparam int DEN_W    = 18;
   // quotient keeps one extra bit for the final rounding
   localparam int QUO_W    = OUT_W + 1;
   localparam int DIV_DEPTH = QUO_W + 1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_MODE = 2'd1,
      ST_NO_END   = 2'd2
   } status_type;

   typedef struct packed {
      logic       neg;
      logic       cap_pos;
      status_type status;
   } tag_type;

   // days before the month; month 0 acts as january, 13..15 as december
   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [8:0] c;
      unique case (m) inside
         4'd0, 4'd1:    c = 9'd0;
         4'd2:          c = 9'd31;
         4'd3:          c = 9'd59;
         4'd4:          c = 9'd90;
         4'd5:          c = 9'd120;
         4'd6:          c = 9'd151;
         4'd7:          c = 9'd181;
         4'd8:          c = 9'd212;
         4'd9:          c = 9'd243;
         4'd10:         c = 9'd273;
         4'd11:         c = 9'd304;
         [4'd12:4'd15]: c = 9'd334;
         default:       c = 9'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/dcf_div.sv
// ----------------------------------------------------------------------------
// dcf_div
// Pipelined restoring divider: quotient of mag * 2^(FRAC_BITS+1) by den,
// one quotient bit per stage, with an overflow flag for results that
// cannot fit the output range.
// ----------------------------------------------------------------------------
module dcf_div #(
   parameter int FRAC_BITS = dcf_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  dcf_pkg::tag_type             in_tag,
   input  logic [dcf_pkg::MAG_W-1:0]    in_mag,
   input  logic [dcf_pkg::DEN_W-1:0]    in_den,
   output logic                         out_valid,
   output dcf_pkg::tag_type             out_tag,
   output logic                         out_ovf,
   output logic [dcf_pkg::QUO_W-1:0]    out_quo
);
   import dcf_pkg::*;

   localparam int SHIFT = OUT_W - FRAC_BITS;
   localparam int XW    = MAG_W + FRAC_BITS + 1;

   logic [MAG_W-1:0] top_bits;
   logic             ovf_in;

   logic             vld_ff [0:QUO_W];
   tag_type          tag_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];
   logic [MAG_W-1:0] mag_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [DEN_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];

   logic [DEN_W:0]   trial  [0:QUO_W-1];
   logic [DEN_W:0]   diff   [0:QUO_W-1];
   logic             take   [0:QUO_W-1];
   logic [XW-1:0]    xw     [0:QUO_W-1];

   // dividend bits above the quotient range must stay below den
   assign top_bits = in_mag >> SHIFT;
   assign ovf_in   = top_bits >= MAG_W'(in_den);

   always_comb begin
      for (int i = 0; i < QUO_W; i++) begin
         xw[i]    = {mag_ff[i], (FRAC_BITS + 1)'(0)};
         trial[i] = {rem_ff[i], xw[i][QUO_W-1-i]};
         take[i]  = trial[i] >= {1'b0, den_ff[i]};
         diff[i]  = trial[i] - {1'b0, den_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_W; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i < QUO_W; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      ovf_ff[0] <= ovf_in;
      mag_ff[0] <= in_mag;
      den_ff[0] <= in_den;
      rem_ff[0] <= ovf_in ? '0 : top_bits[DEN_W-1:0];
      quo_ff[0] <= '0;
      for (int i = 0; i < QUO_W; i++) begin
         tag_ff[i+1] <= tag_ff[i];
         ovf_ff[i+1] <= ovf_ff[i];
         mag_ff[i+1] <= mag_ff[i];
         den_ff[i+1] <= den_ff[i];
         rem_ff[i+1] <= take[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
         quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], take[i]};
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];

endmodule

FILE: hw/rtl/day_count_fraction_core.sv
// ----------------------------------------------------------------------------
// day_count_fraction_core
// Year fraction between two Gregorian dates under ACT/360, ACT/365F,
// ACT/ACT ISDA, ACT/365L and 30/360 US bond, fixed point, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the req_ fields valid; the item is taken at that edge.
//   busy is always low, so an item may be issued on every clock cycle.
//   Each item yields one result on rsp_fraction / rsp_status, shown for
//   exactly one cycle with rsp_valid high.
// Stages: five date and product stages, a 49-stage divider (overflow
//   check plus one quotient bit per stage) and the rounding register.
// Throughput: one item per cycle, set by the fully pipelined divider.
// Results leave in issue order. The receiver has no back pressure; the
//   pipeline never holds.
// Reset: synchronous, clears the valid bits of all stages; items in flight
//   are dropped. The block holds no other state.
// ----------------------------------------------------------------------------
module day_count_fraction_core #(
   parameter int FRAC_BITS = dcf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dcf_pkg::MODE_W-1:0]          req_mode,
   input  logic [dcf_pkg::YEAR_W-1:0]          req_from_year,
   input  logic [dcf_pkg::MONTH_W-1:0]         req_from_month,
   input  logic [dcf_pkg::DAY_W-1:0]           req_from_day,
   input  logic [dcf_pkg::YEAR_W-1:0]          req_to_year,
   input  logic [dcf_pkg::MONTH_W-1:0]         req_to_month,
   input  logic [dcf_pkg::DAY_W-1:0]           req_to_day,
   input  logic                                req_has_end_date,
   input  logic [dcf_pkg::YEAR_W-1:0]          req_nominal_year,
   input  logic [dcf_pkg::MONTH_W-1:0]         req_nominal_month,
   input  logic [dcf_pkg::DAY_W-1:0]           req_nominal_day,
   input  logic                                req_annual_coupon,
   output logic                                rsp_valid,
   output logic signed [dcf_pkg::OUT_W-1:0]    rsp_fraction,
   output logic [dcf_pkg::STATUS_W-1:0]        rsp_status
);
   import dcf_pkg::*;

   localparam int YX_W = YEAR_W + 1;
   localparam logic [QUO_W-1:0] POS_LIM = (QUO_W'(1) << (OUT_W - 1)) - QUO_W'(1);
   localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (OUT_W - 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ACT360  = 3'd0,
      MODE_ACT365F = 3'd1,
      MODE_ACTACT  = 3'd2,
      MODE_ACT365L = 3'd3,
      MODE_BOND    = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] c100;
      logic [5:0] c400;
      logic [7:0] f100;
   } yq_type;

   // reciprocal multiply, exact for x below 43690
   function automatic logic [7:0] div100(input logic [15:0] x);
      logic [31:0] p;
      p = 32'(x) * 32'd41944;
      return p[29:22];
   endfunction

   function automatic logic [5:0] div400(input logic [15:0] x);
      logic [31:0] p;
      p = 32'(x) * 32'd41944;
      return p[29:24];
   endfunction

   function automatic yq_type year_quot(input logic [YX_W-1:0] y);
      yq_type q;
      q.c100 = div100({1'b0, y} + 16'd99);
      q.c400 = div400({1'b0, y} + 16'd399);
      q.f100 = div100({1'b0, y});
      return q;
   endfunction

   // 365*y plus leap years in [0, y)
   function automatic logic [DN_W-1:0] year_base(input logic [YX_W-1:0] y, input yq_type q);
      logic [15:0] y3;
      y3 = {1'b0, y} + 16'd3;
      return DN_W'(y) * DN_W'(365) + DN_W'(y3[15:2]) - DN_W'(q.c100) + DN_W'(q.c400);
   endfunction

   function automatic logic is_leap(input logic [YX_W-1:0] y, input logic [7:0] f100);
      logic [YX_W-1:0] h;
      h = YX_W'({7'd0, f100} * 15'd100);
      return (y[1:0] == 2'd0) && ((y != h) || (f100[1:0] == 2'd0));
   endfunction

   function automatic logic [DN_W-1:0] day_num(input logic [DN_W-1:0] b, input logic lp,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [DAY_W-1:0] d);
      return b + DN_W'(cum_days(m)) + DN_W'(d) + DN_W'((m >= MONTH_W'(3)) && lp);
   endfunction

   // ---------------- stage 1: capture and year quotients ----------------
   logic                s1_vld_ff;
   logic [MODE_W-1:0]   s1_mode_ff;
   logic [YEAR_W-1:0]   s1_fy_ff, s1_ty_ff, s1_ny_ff;
   logic [MONTH_W-1:0]  s1_fm_ff, s1_tm_ff, s1_nm_ff;
   logic [DAY_W-1:0]    s1_fd_ff, s1_td_ff, s1_nd_ff;
   logic                s1_has_end_ff, s1_annual_ff;
   logic [YX_W-1:0]     s1_n4_ff;
   yq_type              s1_qf_ff, s1_qt_ff, s1_qn_ff, s1_q4_ff;
   logic [YX_W-1:0]     n4_in;

   // first multiple of four after the start year
   assign n4_in = {13'({1'b0, req_from_year[YEAR_W-1:2]}) + 13'd1, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff    <= req_mode;
      s1_fy_ff      <= req_from_year;
      s1_fm_ff      <= req_from_month;
      s1_fd_ff      <= req_from_day;
      s1_ty_ff      <= req_to_year;
      s1_tm_ff      <= req_to_month;
      s1_td_ff      <= req_to_day;
      s1_ny_ff      <= req_nominal_year;
      s1_nm_ff      <= req_nominal_month;
      s1_nd_ff      <= req_nominal_day;
      s1_has_end_ff <= req_has_end_date;
      s1_annual_ff  <= req_annual_coupon;
      s1_n4_ff      <= n4_in;
      s1_qf_ff      <= year_quot({1'b0, req_from_year});
      s1_qt_ff      <= year_quot({1'b0, req_to_year});
      s1_qn_ff      <= year_quot({1'b0, req_nominal_year});
      s1_q4_ff      <= year_quot(n4_in);
   end

   // ---------------- stage 2: day numbers ----------------
   logic [DN_W-1:0]     bf_in, bt_in, bn_in, b4_in;
   logic                lf_in, lt_in, ln_in, l4_in;

   logic                s2_vld_ff;
   logic [MODE_W-1:0]   s2_mode_ff;
   logic [DN_W-1:0]     s2_sf_ff, s2_st_ff, s2_se_ff, s2_bf_ff, s2_bt_ff, s2_b4_ff;
   logic                s2_lf_ff, s2_lt_ff, s2_ln_ff, s2_l4_ff;
   logic [YEAR_W-1:0]   s2_fy_ff, s2_ty_ff;
   logic [MONTH_W-1:0]  s2_fm_ff, s2_tm_ff;
   logic [DAY_W-1:0]    s2_fd_ff, s2_td_ff;
   logic                s2_has_end_ff, s2_annual_ff;

   always_comb begin
      bf_in = year_base({1'b0, s1_fy_ff}, s1_qf_ff);
      bt_in = year_base({1'b0, s1_ty_ff}, s1_qt_ff);
      bn_in = year_base({1'b0, s1_ny_ff}, s1_qn_ff);
      b4_in = year_base(s1_n4_ff, s1_q4_ff);
      lf_in = is_leap({1'b0, s1_fy_ff}, s1_qf_ff.f100);
      lt_in = is_leap({1'b0, s1_ty_ff}, s1_qt_ff.f100);
      ln_in = is_leap({1'b0, s1_ny_ff}, s1_qn_ff.f100);
      l4_in = is_leap(s1_n4_ff, s1_q4_ff.f100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mode_ff    <= s1_mode_ff;
      s2_sf_ff      <= day_num(bf_in, lf_in, s1_fm_ff, s1_fd_ff);
      s2_st_ff      <= day_num(bt_in, lt_in, s1_tm_ff, s1_td_ff);
      s2_se_ff      <= day_num(bn_in, ln_in, s1_nm_ff, s1_nd_ff);
      s2_bf_ff      <= bf_in;
      s2_bt_ff      <= bt_in;
      s2_b4_ff      <= b4_in;
      s2_lf_ff      <= lf_in;
      s2_lt_ff      <= lt_in;
      s2_ln_ff      <= ln_in;
      s2_l4_ff      <= l4_in;
      s2_fy_ff      <= s1_fy_ff;
      s2_ty_ff      <= s1_ty_ff;
      s2_fm_ff      <= s1_fm_ff;
      s2_tm_ff      <= s1_tm_ff;
      s2_fd_ff      <= s1_fd_ff;
      s2_td_ff      <= s1_td_ff;
      s2_has_end_ff <= s1_has_end_ff;
      s2_annual_ff  <= s1_annual_ff;
   end

   // ---------------- stage 3: ordering, period terms, bond days ----------------
   logic                rev_in, same_in, l1_in, l2_in;
   logic [DN_W-1:0]     absdays_in, s1x, s2x, b1x, b2x, bound;
   logic [YEAR_W-1:0]   y1x, y2x, k_in;
   logic [8:0]          len1, div365l_in;
   logic signed [9:0]   t1_in, t2_in;
   logic [DAY_W-1:0]    feb1, feb2, bd1, bd2;
   logic signed [14:0]  dy_in;
   logic signed [4:0]   dm_in;
   logic signed [5:0]   dd_in;

   logic                s3_vld_ff;
   logic [MODE_W-1:0]   s3_mode_ff;
   logic                s3_has_end_ff, s3_rev_ff, s3_same_ff, s3_l1_ff, s3_l2_ff;
   logic [DN_W-1:0]     s3_absdays_ff;
   logic [YEAR_W-1:0]   s3_k_ff;
   logic signed [9:0]   s3_t1_ff, s3_t2_ff;
   logic [8:0]          s3_div365l_ff;
   logic signed [14:0]  s3_dy_ff;
   logic signed [4:0]   s3_dm_ff;
   logic signed [5:0]   s3_dd_ff;

   always_comb begin
      rev_in     = s2_st_ff < s2_sf_ff;
      absdays_in = rev_in ? s2_sf_ff - s2_st_ff : s2_st_ff - s2_sf_ff;
      y1x        = rev_in ? s2_ty_ff : s2_fy_ff;
      y2x        = rev_in ? s2_fy_ff : s2_ty_ff;
      s1x        = rev_in ? s2_st_ff : s2_sf_ff;
      s2x        = rev_in ? s2_sf_ff : s2_st_ff;
      b1x        = rev_in ? s2_bt_ff : s2_bf_ff;
      b2x        = rev_in ? s2_bf_ff : s2_bt_ff;
      l1_in      = rev_in ? s2_lt_ff : s2_lf_ff;
      l2_in      = rev_in ? s2_lf_ff : s2_lt_ff;
      same_in    = y2x <= y1x;
      k_in       = y2x - y1x - YEAR_W'(1);
      len1       = l1_in ? 9'd366 : 9'd365;
      // days to the next 1 january, and days since the last one
      t1_in      = 10'(b1x + DN_W'(len1) + DN_W'(1) - s1x);
      t2_in      = 10'(s2x - b2x - DN_W'(1));

      // first 29 february after the start date
      if (s2_lf_ff && (s2_sf_ff < s2_bf_ff + DN_W'(60))) begin
         bound = s2_bf_ff + DN_W'(60);
      end else if (s2_l4_ff) begin
         bound = s2_b4_ff + DN_W'(60);
      end else begin
         bound = s2_b4_ff + DN_W'(1460 + 60);
      end
      if (s2_annual_ff) begin
         div365l_in = (bound <= s2_se_ff) ? 9'd366 : 9'd365;
      end else begin
         div365l_in = s2_ln_ff ? 9'd366 : 9'd365;
      end

      feb1 = s2_lf_ff ? 5'd29 : 5'd28;
      feb2 = s2_lt_ff ? 5'd29 : 5'd28;
      bd1  = s2_fd_ff;
      bd2  = s2_td_ff;
      if ((s2_fm_ff == MONTH_W'(2)) && (s2_fd_ff == feb1)) begin
         if ((s2_tm_ff == MONTH_W'(2)) && (s2_td_ff == feb2)) bd2 = 5'd30;
         bd1 = 5'd30;
      end
      if ((bd2 == 5'd31) && (bd1 >= 5'd30)) bd2 = 5'd30;
      if (bd1 == 5'd31) bd1 = 5'd30;
      dy_in = $signed({1'b0, s2_ty_ff}) - $signed({1'b0, s2_fy_ff});
      dm_in = $signed({1'b0, s2_tm_ff}) - $signed({1'b0, s2_fm_ff});
      dd_in = $signed({1'b0, bd2}) - $signed({1'b0, bd1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_mode_ff    <= s2_mode_ff;
      s3_has_end_ff <= s2_has_end_ff;
      s3_rev_ff     <= rev_in;
      s3_same_ff    <= same_in;
      s3_l1_ff      <= l1_in;
      s3_l2_ff      <= l2_in;
      s3_absdays_ff <= absdays_in;
      s3_k_ff       <= k_in;
      s3_t1_ff      <= t1_in;
      s3_t2_ff      <= t2_in;
      s3_div365l_ff <= div365l_in;
      s3_dy_ff      <= dy_in;
      s3_dm_ff      <= dm_in;
      s3_dd_ff      <= dd_in;
   end

   // ---------------- stage 4: products ----------------
   logic [DEN_W-1:0]    den_aa_in;
   logic [8:0]          len1_4, len2_4;

   logic                s4_vld_ff;
   logic [MODE_W-1:0]   s4_mode_ff;
   logic                s4_has_end_ff, s4_rev_ff, s4_same_ff;
   logic [DN_W-1:0]     s4_absdays_ff;
   logic [8:0]          s4_len1_ff, s4_div365l_ff;
   logic [DEN_W-1:0]    s4_den_aa_ff;
   logic [MAG_W-1:0]    s4_pk_ff;
   logic signed [19:0]  s4_p1_ff, s4_p2_ff;
   logic signed [24:0]  s4_bnum_ff;

   always_comb begin
      len1_4 = s3_l1_ff ? 9'd366 : 9'd365;
      len2_4 = s3_l2_ff ? 9'd366 : 9'd365;
      if (s3_l1_ff && s3_l2_ff) begin
         den_aa_in = DEN_W'(133956);
      end else if (s3_l1_ff || s3_l2_ff) begin
         den_aa_in = DEN_W'(133590);
      end else begin
         den_aa_in = DEN_W'(133225);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_mode_ff    <= s3_mode_ff;
      s4_has_end_ff <= s3_has_end_ff;
      s4_rev_ff     <= s3_rev_ff;
      s4_same_ff    <= s3_same_ff;
      s4_absdays_ff <= s3_absdays_ff;
      s4_len1_ff    <= len1_4;
      s4_div365l_ff <= s3_div365l_ff;
      s4_den_aa_ff  <= den_aa_in;
      s4_pk_ff      <= MAG_W'(s3_k_ff) * MAG_W'(den_aa_in);
      s4_p1_ff      <= s3_t1_ff * $signed({1'b0, len2_4});
      s4_p2_ff      <= s3_t2_ff * $signed({1'b0, len1_4});
      s4_bnum_ff    <= $signed(25'(s3_dy_ff)) * 25'sd360
                     + $signed(25'(s3_dm_ff)) * 25'sd30
                     + $signed(25'(s3_dd_ff));
   end

   // ---------------- stage 5: numerator and divisor select ----------------
   logic signed [33:0]  num;
   logic                numneg;
   logic [MAG_W-1:0]    absnum, bmag;
   logic [MAG_W-1:0]    mag_in;
   logic [DEN_W-1:0]    den_in;
   tag_type             tag_in;

   logic                s5_vld_ff;
   logic [MAG_W-1:0]    s5_mag_ff;
   logic [DEN_W-1:0]    s5_den_ff;
   tag_type             s5_tag_ff;

   always_comb begin
      num    = $signed({2'b00, s4_pk_ff}) + 34'(s4_p1_ff) + 34'(s4_p2_ff);
      numneg = num[33];
      absnum = numneg ? MAG_W'(-num) : MAG_W'(num);
      bmag   = s4_bnum_ff[24] ? MAG_W'(-s4_bnum_ff) : MAG_W'(s4_bnum_ff);

      mag_in         = MAG_W'(s4_absdays_ff);
      den_in         = DEN_W'(360);
      tag_in.neg     = s4_rev_ff;
      tag_in.cap_pos = 1'b0;
      tag_in.status  = ST_OK;
      unique case (s4_mode_ff)
         MODE_ACT360: begin
            den_in = DEN_W'(360);
         end
         MODE_ACT365F: begin
            den_in = DEN_W'(365);
         end
         MODE_ACTACT: begin
            if (s4_same_ff) begin
               den_in         = DEN_W'(s4_len1_ff);
               tag_in.cap_pos = s4_rev_ff;
            end else begin
               // a reversed period negates an already saturated value
               mag_in         = absnum;
               den_in         = s4_den_aa_ff;
               tag_in.neg     = s4_rev_ff ^ numneg;
               tag_in.cap_pos = s4_rev_ff && !numneg;
            end
         end
         MODE_ACT365L: begin
            if (s4_has_end_ff) begin
               den_in = DEN_W'(s4_div365l_ff);
            end else begin
               mag_in        = '0;
               tag_in.neg    = 1'b0;
               tag_in.status = ST_NO_END;
            end
         end
         MODE_BOND: begin
            mag_in     = bmag;
            tag_in.neg = s4_bnum_ff[24];
         end
         default: begin
            mag_in        = '0;
            tag_in.neg    = 1'b0;
            tag_in.status = ST_BAD_MODE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_mag_ff <= mag_in;
      s5_den_ff <= den_in;
      s5_tag_ff <= tag_in;
   end

   // ---------------- divider ----------------
   logic                dv_valid, dv_ovf;
   tag_type             dv_tag;
   logic [QUO_W-1:0]    dv_quo;

   dcf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_vld_ff),
      .in_tag    (s5_tag_ff),
      .in_mag    (s5_mag_ff),
      .in_den    (s5_den_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_ovf   (dv_ovf),
      .out_quo   (dv_quo)
   );

   // ---------------- rounding and saturation ----------------
   logic [QUO_W:0]      qsum;
   logic [QUO_W-1:0]    rnd, cap, mv;
   logic [OUT_W-1:0]    frac_in;

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_fraction_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   always_comb begin
      // quotient carries one extra bit: half up on the magnitude
      qsum = {1'b0, dv_quo} + (QUO_W + 1)'(1);
      rnd  = qsum[QUO_W:1];
      if (dv_tag.neg) begin
         cap = dv_tag.cap_pos ? POS_LIM : NEG_LIM;
      end else begin
         cap = POS_LIM;
      end
      mv = (dv_ovf || (rnd > cap)) ? cap : rnd;
      frac_in = dv_tag.neg ? OUT_W'(-mv) : OUT_W'(mv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_fraction_ff <= frac_in;
      rsp_status_ff   <= dv_tag.status;
   end

   assign busy         = 1'b0;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fraction = rsp_fraction_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   // five front stages, the divider, and the output register
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, DIV_DEPTH + 6))
      else $error("result without an accepted item");

   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_mode, DIV_DEPTH + 6) > MODE_BOND)
      |-> rsp_status == ST_BAD_MODE)
      else $error("unknown basis not flagged");

   a_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_mode == MODE_ACT365L && !req_has_end_date, DIV_DEPTH + 6)
      |-> rsp_status == ST_NO_END)
      else $error("missing end date not flagged");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_fraction == '0)
      else $error("error result with nonzero fraction");
`endif

endmodule

FILE: tb/dcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_checker
// Watches the item and result channels of the day count fraction core,
// computes the expected year fraction and status of every accepted item and
// compares each result with the oldest expectation in issue order.
// ----------------------------------------------------------------------------
module dcf_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [dcf_pkg::MODE_W-1:0]         req_mode,
   input  logic [dcf_pkg::YEAR_W-1:0]         req_from_year,
   input  logic [dcf_pkg::MONTH_W-1:0]        req_from_month,
   input  logic [dcf_pkg::DAY_W-1:0]          req_from_day,
   input  logic [dcf_pkg::YEAR_W-1:0]         req_to_year,
   input  logic [dcf_pkg::MONTH_W-1:0]        req_to_month,
   input  logic [dcf_pkg::DAY_W-1:0]          req_to_day,
   input  logic                               req_has_end_date,
   input  logic [dcf_pkg::YEAR_W-1:0]         req_nominal_year,
   input  logic [dcf_pkg::MONTH_W-1:0]        req_nominal_month,
   input  logic [dcf_pkg::DAY_W-1:0]          req_nominal_day,
   input  logic                               req_annual_coupon,
   input  logic                               rsp_valid,
   input  logic signed [dcf_pkg::OUT_W-1:0]   rsp_fraction,
   input  logic [dcf_pkg::STATUS_W-1:0]       rsp_status,
   output int                                 fail_count,
   output int                                 pending_count
);
   import dcf_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   typedef struct {
      logic [OUT_W-1:0] fraction;
      status_type       status;
   } fraction_result;

   localparam logic [63:0] OUT_MASK  = (64'd1 << OUT_W) - 1;
   localparam logic [63:0] POS_LIMIT = (64'd1 << (OUT_W - 1)) - 1;
   localparam logic [63:0] NEG_LIMIT = 64'd1 << (OUT_W - 1);

   fraction_result expected_q[$];

   function automatic bit leap_year(longint unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic longint unsigned days_in_year(longint unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic longint unsigned serial_day(longint unsigned y, longint unsigned m,
                                                  longint unsigned d);
      longint unsigned month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                           304, 334};
      longint unsigned n;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      n += month_start[m - 1] + d;
      if (m > 2 && leap_year(y)) n += 1;
      return n;
   endfunction

   // round num/den to nearest, ties away from zero, saturate to the port width
   function automatic logic [63:0] round_fixed(longint num, longint unsigned den);
      bit neg;
      logic [63:0] mag, q, r, v;
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if (q > (POS_LIMIT >> FB) + 1)
         v = NEG_LIMIT + 1;
      else
         v = (q << FB) + (((r << FB) * 2 + den) / (2 * den));
      if (neg) begin
         if (v > NEG_LIMIT) v = NEG_LIMIT;
         return (-v) & OUT_MASK;
      end
      if (v > POS_LIMIT) v = POS_LIMIT;
      return v & OUT_MASK;
   endfunction

   function automatic logic [63:0] isda_fraction(longint unsigned y1, longint unsigned s1,
                                                 longint unsigned y2, longint unsigned s2);
      longint unsigned len1, len2, jan1, jan2;
      longint num;
      len1 = days_in_year(y1);
      if (y2 <= y1) return round_fixed(longint'(s2) - longint'(s1), len1);
      len2 = days_in_year(y2);
      jan1 = serial_day(y1 + 1, 1, 1);
      jan2 = serial_day(y2, 1, 1);
      num = longint'(y2 - y1 - 1) * longint'(len1 * len2)
          + (longint'(jan1) - longint'(s1)) * longint'(len2)
          + (longint'(s2) - longint'(jan2)) * longint'(len1);
      return round_fixed(num, len1 * len2);
   endfunction

   // 366 when a 29 february lies in (from, nominal]
   function automatic longint unsigned coupon_divisor(longint unsigned yf, longint unsigned sf,
                                                      longint unsigned se);
      longint unsigned cand;
      cand = yf;
      if (!(leap_year(yf) && sf < serial_day(yf, 2, 29))) begin
         cand = yf + 1;
         for (int k = 0; k < 8 && !leap_year(cand); k++) cand++;
      end
      return serial_day(cand, 2, 29) <= se ? 366 : 365;
   endfunction

   function automatic fraction_result predict_fraction(
      logic [MODE_W-1:0] mode,
      logic [YEAR_W-1:0] fy, logic [MONTH_W-1:0] fm, logic [DAY_W-1:0] fd,
      logic [YEAR_W-1:0] ty, logic [MONTH_W-1:0] tm, logic [DAY_W-1:0] td,
      logic has_end,
      logic [YEAR_W-1:0] ny, logic [MONTH_W-1:0] nm, logic [DAY_W-1:0] nd,
      logic annual);
      fraction_result res;
      longint unsigned sf, st, se, den;
      longint days, d1, d2, feb1, feb2;
      sf = serial_day(fy, fm, fd);
      st = serial_day(ty, tm, td);
      days = longint'(st) - longint'(sf);
      res.fraction = '0;
      res.status = ST_OK;
      case (mode)
         3'd0: res.fraction = round_fixed(days, 360);
         3'd1: res.fraction = round_fixed(days, 365);
         3'd2: begin
            if (st < sf)
               res.fraction = (-isda_fraction(ty, st, fy, sf)) & OUT_MASK;
            else
               res.fraction = isda_fraction(fy, sf, ty, st);
         end
         3'd3: begin
            if (!has_end) begin
               res.status = ST_NO_END;
            end else begin
               se = serial_day(ny, nm, nd);
               den = annual ? coupon_divisor(fy, sf, se) : days_in_year(ny);
               res.fraction = round_fixed(days, den);
            end
         end
         3'd4: begin
            d1 = fd;
            d2 = td;
            feb1 = leap_year(fy) ? 29 : 28;
            feb2 = leap_year(ty) ? 29 : 28;
            if (fm == 2 && d1 == feb1) begin
               if (tm == 2 && d2 == feb2) d2 = 30;
               d1 = 30;
            end
            if (d2 == 31 && d1 >= 30) d2 = 30;
            if (d1 == 31) d1 = 30;
            res.fraction = round_fixed(360 * (longint'(ty) - longint'(fy))
                                       + 30 * (longint'(tm) - longint'(fm)) + (d2 - d1), 360);
         end
         default: res.status = ST_BAD_MODE;
      endcase
      return res;
   endfunction

   assign pending_count = expected_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      fraction_result exp_res;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result fraction=%0h status=%0d", rsp_fraction, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_q.pop_front();
               if (rsp_fraction !== exp_res.fraction) begin
                  $error("fraction: expected %0h, actual %0h", exp_res.fraction, rsp_fraction);
                  fail_count <= fail_count + 1;
               end
               if (rsp_status !== exp_res.status) begin
                  $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_q.push_back(predict_fraction(req_mode, req_from_year, req_from_month,
               req_from_day, req_to_year, req_to_month, req_to_day, req_has_end_date,
               req_nominal_year, req_nominal_month, req_nominal_day, req_annual_coupon));
      end
   end

endmodule

FILE: tb/tb_day_count_fraction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_day_count_fraction_core
// Drives directed and random date pairs through every basis with random
// gaps; the checker predicts each year fraction and compares the results.
// ----------------------------------------------------------------------------
module tb_day_count_fraction_core;
   import dcf_pkg::*;

   localparam int RANDOM_ITEMS = 880;
   localparam int LATENCY = 55;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [YEAR_W-1:0]         req_from_year = 14'd2000;
   logic [MONTH_W-1:0]        req_from_month = 4'd1;
   logic [DAY_W-1:0]          req_from_day = 5'd1;
   logic [YEAR_W-1:0]         req_to_year = 14'd2000;
   logic [MONTH_W-1:0]        req_to_month = 4'd1;
   logic [DAY_W-1:0]          req_to_day = 5'd1;
   logic                      req_has_end_date = 1'b0;
   logic [YEAR_W-1:0]         req_nominal_year = 14'd2000;
   logic [MONTH_W-1:0]        req_nominal_month = 4'd1;
   logic [DAY_W-1:0]          req_nominal_day = 5'd1;
   logic                      req_annual_coupon = 1'b0;
   logic                      rsp_valid;
   logic signed [OUT_W-1:0]   rsp_fraction;
   logic [STATUS_W-1:0]       rsp_status;
   int                        fail_count;
   int                        pending_count;
   bit                        gaps_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   day_count_fraction_core dut (.*);

   dcf_checker checker_i (.*);

   // issue one item, holding start until it is taken
   task automatic issue_dates(input logic [2:0] mode,
                              input int fy, input int fm, input int fd,
                              input int ty, input int tm, input int td,
                              input bit has_end, input int ny, input int nm, input int nd,
                              input bit annual);
      while (gaps_on && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_from_year <= fy;
      req_from_month <= fm;
      req_from_day <= fd;
      req_to_year <= ty;
      req_to_month <= tm;
      req_to_day <= td;
      req_has_end_date <= has_end;
      req_nominal_year <= ny;
      req_nominal_month <= nm;
      req_nominal_day <= nd;
      req_annual_coupon <= annual;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic issue_random();
      int fy, ty, ny, span;
      logic [2:0] mode;
      mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      case ($urandom_range(3))
         0: fy = $urandom_range(16383);
         1: fy = $urandom_range(9999, 1);
         default: fy = $urandom_range(2100, 1890);
      endcase
      span = $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(12);
      ty = ($urandom_range(3) == 0) ? fy - span : fy + span;
      if (ty < 0) ty = 0;
      if (ty > 16383) ty = 16383;
      ny = ($urandom_range(4) == 0) ? $urandom_range(16383) : ty + $urandom_range(1);
      if (ny > 16383) ny = 16383;
      issue_dates(mode,
         fy, $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(12, 1),
         $urandom_range(2) == 0 ? $urandom_range(31) : $urandom_range(31, 27),
         ty, $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(12, 1),
         $urandom_range(2) == 0 ? $urandom_range(31) : $urandom_range(31, 27),
         $urandom_range(5) != 0, ny, $urandom_range(15), $urandom_range(31),
         $urandom_range(1));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed items
      for (int m = 0; m < 8; m++)
         issue_dates(m, 2000, 1, 1, 2001, 3, 1, 1'b1, 2001, 3, 1, 1'b1);
      issue_dates(3'd2, 2023, 12, 15, 2025, 1, 10, 1'b0, 1, 1, 1, 1'b0);   // spans year ends
      issue_dates(3'd2, 2025, 1, 10, 2023, 12, 15, 1'b0, 1, 1, 1, 1'b0);   // reversed
      issue_dates(3'd3, 2023, 3, 1, 2024, 3, 1, 1'b0, 2024, 3, 1, 1'b1);   // no end date
      issue_dates(3'd3, 2023, 3, 1, 2024, 3, 1, 1'b1, 2024, 3, 1, 1'b1);   // feb 29 inside
      issue_dates(3'd3, 2024, 3, 1, 2025, 3, 1, 1'b1, 2025, 3, 1, 1'b1);
      issue_dates(3'd3, 2023, 3, 1, 2024, 3, 1, 1'b1, 2024, 3, 1, 1'b0);
      issue_dates(3'd4, 2024, 2, 29, 2025, 2, 28, 1'b0, 1, 1, 1, 1'b0);    // feb end to feb end
      issue_dates(3'd4, 2023, 2, 28, 2023, 3, 31, 1'b0, 1, 1, 1, 1'b0);
      issue_dates(3'd4, 2023, 1, 31, 2023, 3, 31, 1'b0, 1, 1, 1, 1'b0);    // 31st rules
      issue_dates(3'd4, 2023, 1, 15, 2023, 3, 31, 1'b0, 1, 1, 1, 1'b0);
      issue_dates(3'd0, 0, 0, 0, 16383, 15, 31, 1'b1, 16383, 15, 31, 1'b1); // saturate high
      issue_dates(3'd0, 16383, 15, 31, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);       // saturate low
      issue_dates(3'd4, 0, 15, 31, 16383, 0, 0, 1'b1, 0, 0, 0, 1'b0);
      issue_dates(3'd1, 1900, 2, 29, 2100, 2, 30, 1'b0, 9999, 12, 31, 1'b0);
      // wait for every result before the random part
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps_on = !(i >= 300 && i < 450);
         issue_random();
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
